// ===== hw/rtl/avagc_pkg.sv =====
`timescale 1ns / 1ps

package avagc_pkg;

    // Serial arithmetic unit sizes.
    localparam int MUL_W  = 32;
    localparam int DIV_W  = 48;
    localparam int DIV_DW = 32;

    // AGC mode codes.
    localparam logic [1:0] MODE_MANUAL = 2'd0;
    localparam logic [1:0] MODE_NORMAL = 2'd1;
    localparam logic [1:0] MODE_VIVID  = 2'd2;
    localparam logic [1:0] MODE_LAZY   = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_AGC_MODE      = 3'd0;
    localparam logic [2:0] CFG_SQUELCH       = 3'd1;
    localparam logic [2:0] CFG_MANUAL_GAIN   = 3'd2;
    localparam logic [2:0] CFG_INPUT_LEVEL   = 3'd3;
    localparam logic [2:0] CFG_PEAK_BIN      = 3'd4;
    localparam logic [2:0] CFG_PEAK_VOL_LIM  = 3'd5;

    localparam logic [21:0] MULT_MIN  = 22'd1024;
    localparam logic [21:0] MULT_MAX  = 22'd2097152;
    localparam logic [21:0] MULT_ONE  = 22'd65536;

    typedef struct packed {
        logic [14:0] mic_level;
        logic [31:0] now_ms;
        logic [31:0] override_ms;
    } t_in_item;

    typedef struct packed {
        logic [15:0] volume_smooth;
        logic [7:0]  volume_raw;
        logic [15:0] agc_volume_smooth;
        logic [7:0]  agc_volume_raw;
        logic [21:0] gain_multiplier;
        logic        peak_event;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic [2*MUL_W-1:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic [7:0]  zone_low;
        logic [7:0]  zone_high;
        logic [8:0]  zone_stop;
        logic [7:0]  target0;
        logic [7:0]  target0_up;
        logic [7:0]  target1;
        logic [7:0]  kp;
        logic [7:0]  ki;
        logic [13:0] decay;
        logic [4:0]  smooth_div;
        logic [19:0] kp_div_fast;
        logic [19:0] kp_div_slow;
        logic [27:0] ki_div_fast;
        logic [27:0] ki_div_slow;
    } t_preset;

    typedef enum logic [4:0] {
        S_IDLE, S_DC_DIV, S_DC_FIX, S_ENV_DIV, S_VOL_MUL, S_VOL_DIV,
        S_PH_MUL, S_PH_UPD, S_PH_DMUL, S_PH_DDIV, S_PH_CLR, S_LVL_MUL,
        S_PHZ_MUL, S_SIL, S_I91_MUL, S_I91_DIV, S_TG_DIV, S_ERR, S_IE_DIV,
        S_I9_MUL, S_I9_DIV, S_KP_MUL, S_KP_DIV, S_KI_MUL, S_KI_DIV, S_TSUM,
        S_OUT_MUL, S_RAW_DIV, S_SM_DIV, S_FINISH
    } t_state;

    // Divisors of the PI terms are 100*f and 100*f*256 folded into constants.
    function automatic t_preset preset(input logic [1:0] mode);
        t_preset p;
        unique case (mode) inside
            MODE_MANUAL, MODE_NORMAL: begin
                p = '{8'd32, 8'd240, 9'd336, 8'd112, 8'd88, 8'd220, 8'd60, 8'd170,
                      14'd9994, 5'd12, 20'd19200, 20'd614400, 28'd4915200,
                      28'd157286400};
            end
            MODE_VIVID: begin
                p = '{8'd28, 8'd240, 9'd448, 8'd144, 8'd64, 8'd224, 8'd150, 8'd185,
                      14'd9985, 5'd6, 20'd12800, 20'd409600, 28'd3276800,
                      28'd104857600};
            end
            default: begin
                p = '{8'd36, 8'd248, 9'd304, 8'd164, 8'd116, 8'd216, 8'd65, 8'd120,
                      14'd9997, 5'd16, 20'd25600, 20'd819200, 28'd6553600,
                      28'd209715200};
            end
        endcase
        return p;
    endfunction

    // Two's complement of a magnitude with a sign, one bit wider.
    function automatic logic [32:0] apply_sign(input logic neg, input logic [31:0] mag);
        logic [32:0] v;
        v = {1'b0, mag};
        return neg ? (~v + 33'd1) : v;
    endfunction

endpackage

// ===== hw/rtl/audio_volume_agc_pi_loop_unit.sv =====
`timescale 1ns / 1ps

// Audio level meter with automatic gain control. Each input transfer carries the peak
// magnitude of one audio block and the time; each produces exactly one result transfer
// with the manual-gain volume, its running average (weight 1/16), the AGC volume (raw
// and smoothed), the current gain multiplier and a peak flag. The block works on one
// item at a time: the arithmetic runs on a bit-serial multiplier and a bit-serial
// divider driven by a sequencer, which runs the gain control steps only when a control
// tick is due. The next item is taken as soon as the sequencer is idle, while the
// previous result may still wait in the output register. Configuration writes take
// effect at once and are meant to be made between items.
module audio_volume_agc_pi_loop_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  avagc_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output avagc_pkg::t_out_item o_out_data,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    avagc_pkg::t_state r_state, n_state;

    // Configuration.
    logic [1:0] r_agc_mode;
    logic [7:0] r_squelch, r_manual_gain, r_input_level, r_peak_bin, r_peak_vol_lim;

    // Loop state.
    logic [31:0] r_dc, n_dc, r_env, n_env, r_ph, n_ph;
    logic [23:0] r_avg, n_avg, r_smooth, n_smooth;
    logic [21:0] r_mult, n_mult;
    logic [31:0] r_integ, n_integ;
    logic [7:0]  r_raw, n_raw;
    logic [2:0]  r_prev, n_prev;
    logic [31:0] r_lct, n_lct, r_lpt, n_lpt;

    // Per-item working registers.
    logic [14:0] r_mic, n_mic;
    logic [31:0] r_now, n_now, r_ovr, n_ovr;
    logic [47:0] r_prod, n_prod;
    logic [53:0] r_lvl, n_lvl;
    logic        r_zone_old, n_zone_old, r_zone_new, n_zone_new;
    logic [23:0] r_adj, n_adj, r_tq, n_tq;
    logic [21:0] r_temp, n_temp;
    logic [22:0] r_err, n_err;
    logic        r_fast, n_fast, r_peak, n_peak;
    logic [32:0] r_q1, n_q1, r_q2, n_q2;
    logic        r_issued, n_issued;
    logic        r_out_valid, n_out_valid;
    avagc_pkg::t_out_item r_out, n_out;

    avagc_pkg::t_mul_req mul_req;
    avagc_pkg::t_mul_rsp mul_rsp;
    avagc_pkg::t_div_req div_req;
    avagc_pkg::t_div_rsp div_rsp;
    avagc_pkg::t_preset  pre;

    logic [31:0] m32, dc_mag, integ_mag, tnow, dc_fixed, env_sq;
    logic [34:0] env_num;
    logic [36:0] dc_fix_sum;
    logic [15:0] mgil;
    logic [48:0] vol_sum;
    logic [27:0] avg_sum;
    logic [21:0] err_mag;
    logic [22:0] err_next;
    logic [32:0] dph, dph_half, q_integ, q_err, q_err_int, isum, tsum;
    logic [47:0] t_out;
    logic [26:0] raw_num;
    logic [24:0] sm_half;
    logic [23:0] sm_mag;
    logic [7:0]  tg;
    logic [8:0]  sq_low;
    logic        tick, silent, ph_rise, ph_follow, peak_ok, err_cond, sm_neg, load_out;

    assign pre       = avagc_pkg::preset(r_agc_mode);
    assign m32       = {1'b0, r_mic, 16'd0};
    assign dc_mag    = (m32 >= r_dc) ? (m32 - r_dc) : (r_dc - m32);
    assign env_num   = {3'd0, dc_mag} + {1'b0, r_env, 2'd0};
    assign dc_fix_sum = {r_dc, 5'd0} - {5'd0, r_dc} + {5'd0, m32};
    assign dc_fixed  = dc_fix_sum[36:5];
    assign mgil      = r_manual_gain * r_input_level;
    assign integ_mag = r_integ[31] ? (~r_integ + 32'd1) : r_integ;
    assign err_mag   = r_err[22] ? 22'(~r_err + 23'd1) : r_err[21:0];
    assign err_next  = {1'b0, r_temp} - {1'b0, r_mult};
    assign tnow      = (r_ovr != 32'd0 && r_ovr < r_now) ? r_ovr : r_now;
    assign tick      = (tnow - r_lct) > 32'd2;
    assign silent    = (r_env < 32'd131072) || (r_ph < 32'd65536);
    assign ph_rise   = (r_ph < r_env) && (r_env > 32'd32768);
    assign ph_follow = r_zone_old && (r_agc_mode != avagc_pkg::MODE_MANUAL);
    assign peak_ok   = (r_peak_bin < 8'd12 || r_peak_vol_lim == 8'd0)
                       && ((r_now - r_lpt) > 32'd80) && (r_avg > 24'd65536);
    assign err_cond  = (r_temp > 22'd5570) && (r_temp < 22'd425984) && r_zone_new;
    assign dph       = {1'b0, r_env} - {1'b0, r_ph};
    assign dph_half  = 33'($signed(dph + {32'd0, dph[32]}) >>> 1);
    assign tg        = (r_lvl <= {14'd0, pre.target0_up, 32'd0}) ? pre.target0 : pre.target1;
    assign sq_low    = {1'b0, r_squelch} + {1'b0, pre.zone_low};
    assign avg_sum   = {r_avg, 4'd0} - {4'd0, r_avg} + {4'd0, r_adj};
    assign vol_sum   = {1'b0, div_rsp.quot} + {21'd0, r_env[31:4]};
    assign q_integ   = avagc_pkg::apply_sign(r_integ[31], div_rsp.quot[31:0]);
    assign q_err     = avagc_pkg::apply_sign(r_err[22], div_rsp.quot[31:0]);
    assign q_err_int = q_err;
    assign isum      = {r_integ[31], r_integ} + q_err_int;
    assign tsum      = {11'd0, r_mult} + r_q1 + r_q2;
    assign t_out     = mul_rsp.prod[63:16];
    assign raw_num   = {1'b0, r_tq, 2'd0} + {3'd0, r_raw, 16'd0};
    assign sm_half   = ({1'b0, r_tq} + {1'b0, r_smooth}) >> 1;
    assign sm_neg    = r_tq < r_smooth;
    assign sm_mag    = sm_neg ? (r_smooth - r_tq) : (r_tq - r_smooth);
    assign env_sq    = ((div_rsp.quot[31:0] <= {8'd0, r_squelch, 16'd0})
                       || (r_squelch == 8'd0 && div_rsp.quot[31:0] < 32'd16384))
                       ? 32'd0 : div_rsp.quot[31:0];
    assign load_out  = (r_state == avagc_pkg::S_FINISH) && (!r_out_valid || i_out_ready);

    avagc_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mul_req),
        .o_rsp  (mul_rsp)
    );

    avagc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            avagc_pkg::S_IDLE:    if (i_in_valid) n_state = avagc_pkg::S_DC_DIV;
            avagc_pkg::S_DC_DIV:  if (div_rsp.done) n_state = avagc_pkg::S_DC_FIX;
            avagc_pkg::S_DC_FIX:  n_state = avagc_pkg::S_ENV_DIV;
            avagc_pkg::S_ENV_DIV: if (div_rsp.done) n_state = avagc_pkg::S_VOL_MUL;
            avagc_pkg::S_VOL_MUL: if (mul_rsp.done) n_state = avagc_pkg::S_VOL_DIV;
            avagc_pkg::S_VOL_DIV: if (div_rsp.done) n_state = avagc_pkg::S_PH_MUL;
            avagc_pkg::S_PH_MUL:  if (mul_rsp.done) n_state = avagc_pkg::S_PH_UPD;
            avagc_pkg::S_PH_UPD: begin
                if (ph_rise || ph_follow) n_state = avagc_pkg::S_PH_CLR;
                else n_state = avagc_pkg::S_PH_DMUL;
            end
            avagc_pkg::S_PH_DMUL: if (mul_rsp.done) n_state = avagc_pkg::S_PH_DDIV;
            avagc_pkg::S_PH_DDIV: if (div_rsp.done) n_state = avagc_pkg::S_PH_CLR;
            avagc_pkg::S_PH_CLR: begin
                n_state = tick ? avagc_pkg::S_LVL_MUL : avagc_pkg::S_OUT_MUL;
            end
            avagc_pkg::S_LVL_MUL: if (mul_rsp.done) n_state = avagc_pkg::S_PHZ_MUL;
            avagc_pkg::S_PHZ_MUL: if (mul_rsp.done) n_state = avagc_pkg::S_SIL;
            avagc_pkg::S_SIL: begin
                if (!silent) n_state = avagc_pkg::S_TG_DIV;
                else if (integ_mag < 32'd167772) n_state = avagc_pkg::S_ERR;
                else n_state = avagc_pkg::S_I91_MUL;
            end
            avagc_pkg::S_I91_MUL: if (mul_rsp.done) n_state = avagc_pkg::S_I91_DIV;
            avagc_pkg::S_I91_DIV: if (div_rsp.done) n_state = avagc_pkg::S_ERR;
            avagc_pkg::S_TG_DIV:  if (div_rsp.done) n_state = avagc_pkg::S_ERR;
            avagc_pkg::S_ERR: begin
                n_state = err_cond ? avagc_pkg::S_IE_DIV : avagc_pkg::S_I9_MUL;
            end
            avagc_pkg::S_IE_DIV:  if (div_rsp.done) n_state = avagc_pkg::S_KP_MUL;
            avagc_pkg::S_I9_MUL:  if (mul_rsp.done) n_state = avagc_pkg::S_I9_DIV;
            avagc_pkg::S_I9_DIV:  if (div_rsp.done) n_state = avagc_pkg::S_KP_MUL;
            avagc_pkg::S_KP_MUL:  if (mul_rsp.done) n_state = avagc_pkg::S_KP_DIV;
            avagc_pkg::S_KP_DIV:  if (div_rsp.done) n_state = avagc_pkg::S_KI_MUL;
            avagc_pkg::S_KI_MUL:  if (mul_rsp.done) n_state = avagc_pkg::S_KI_DIV;
            avagc_pkg::S_KI_DIV:  if (div_rsp.done) n_state = avagc_pkg::S_TSUM;
            avagc_pkg::S_TSUM:    n_state = avagc_pkg::S_OUT_MUL;
            avagc_pkg::S_OUT_MUL: if (mul_rsp.done) n_state = avagc_pkg::S_RAW_DIV;
            avagc_pkg::S_RAW_DIV: begin
                if (div_rsp.done) begin
                    n_state = (r_tq < 24'd65536) ? avagc_pkg::S_FINISH : avagc_pkg::S_SM_DIV;
                end
            end
            avagc_pkg::S_SM_DIV:  if (div_rsp.done) n_state = avagc_pkg::S_FINISH;
            avagc_pkg::S_FINISH:  if (!r_out_valid || i_out_ready) n_state = avagc_pkg::S_IDLE;
            default:              n_state = avagc_pkg::S_IDLE;
        endcase
    end

    // Datapath and unit requests.
    always_comb begin
        n_dc = r_dc; n_env = r_env; n_ph = r_ph; n_avg = r_avg; n_smooth = r_smooth;
        n_mult = r_mult; n_integ = r_integ; n_raw = r_raw; n_prev = r_prev;
        n_lct = r_lct; n_lpt = r_lpt;
        n_mic = r_mic; n_now = r_now; n_ovr = r_ovr; n_prod = r_prod; n_lvl = r_lvl;
        n_zone_old = r_zone_old; n_zone_new = r_zone_new; n_adj = r_adj; n_tq = r_tq;
        n_temp = r_temp; n_err = r_err; n_fast = r_fast; n_peak = r_peak;
        n_q1 = r_q1; n_q2 = r_q2;
        n_issued = r_issued;
        mul_req = '0;
        div_req = '0;
        n_out = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            avagc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_mic  = i_in_data.mic_level;
                    n_now  = i_in_data.now_ms;
                    n_ovr  = i_in_data.override_ms;
                    n_peak = 1'b0;
                    if (r_prev != {1'b0, r_agc_mode}) n_integ = 32'd0;
                end
            end
            avagc_pkg::S_DC_DIV: begin
                div_req.start    = !r_issued;
                div_req.dividend = {16'd0, dc_mag};
                div_req.divisor  = 32'd12288;
                if (div_rsp.done) begin
                    n_dc = (m32 >= r_dc) ? (r_dc + div_rsp.quot[31:0])
                                         : (r_dc - div_rsp.quot[31:0]);
                end
            end
            avagc_pkg::S_DC_FIX: begin
                if (m32 < r_dc) n_dc = dc_fixed;
            end
            avagc_pkg::S_ENV_DIV: begin
                div_req.start    = !r_issued;
                div_req.dividend = {13'd0, env_num};
                div_req.divisor  = 32'd5;
                if (div_rsp.done) n_env = env_sq;
            end
            avagc_pkg::S_VOL_MUL: begin
                mul_req.start = !r_issued;
                mul_req.a     = r_env;
                mul_req.b     = {16'd0, mgil};
                if (mul_rsp.done) n_prod = mul_rsp.prod[47:0];
            end
            avagc_pkg::S_VOL_DIV: begin
                div_req.start    = !r_issued;
                div_req.dividend = r_prod;
                div_req.divisor  = 32'd5120;
                if (div_rsp.done) begin
                    n_adj = (vol_sum > 49'h0FF0000) ? 24'hFF0000 : vol_sum[23:0];
                end
            end
            avagc_pkg::S_PH_MUL: begin
                mul_req.start = !r_issued;
                mul_req.a     = r_ph;
                mul_req.b     = {10'd0, r_mult};
                if (mul_rsp.done) n_zone_old = mul_rsp.prod > {23'd0, pre.zone_stop, 32'd0};
            end
            avagc_pkg::S_PH_UPD: begin
                if (ph_rise) begin
                    n_ph = r_ph + ((r_env - r_ph) >> 1);
                    if (peak_ok) begin
                        n_peak = 1'b1;
                        n_lpt  = r_now;
                    end
                end else if (ph_follow) begin
                    n_ph = r_ph + dph_half[31:0];
                end
            end
            avagc_pkg::S_PH_DMUL: begin
                mul_req.start = !r_issued;
                mul_req.a     = r_ph;
                mul_req.b     = {18'd0, pre.decay};
                if (mul_rsp.done) n_prod = mul_rsp.prod[47:0];
            end
            avagc_pkg::S_PH_DDIV: begin
                div_req.start    = !r_issued;
                div_req.dividend = r_prod;
                div_req.divisor  = 32'd10000;
                if (div_rsp.done) n_ph = div_rsp.quot[31:0];
            end
            avagc_pkg::S_PH_CLR: begin
                if (r_ph < 32'd32768) n_ph = 32'd0;
                n_avg  = avg_sum[27:4];
                n_temp = r_mult;
                if (tick) n_lct = tnow;
            end
            avagc_pkg::S_LVL_MUL: begin
                mul_req.start = !r_issued;
                mul_req.a     = r_env;
                mul_req.b     = {10'd0, r_mult};
                if (mul_rsp.done) n_lvl = mul_rsp.prod[53:0];
            end
            avagc_pkg::S_PHZ_MUL: begin
                mul_req.start = !r_issued;
                mul_req.a     = r_ph;
                mul_req.b     = {10'd0, r_mult};
                if (mul_rsp.done) n_zone_new = mul_rsp.prod < {23'd0, pre.zone_stop, 32'd0};
            end
            avagc_pkg::S_SIL: begin
                if (silent && integ_mag < 32'd167772) n_integ = 32'd0;
            end
            avagc_pkg::S_I91_MUL: begin
                mul_req.start = !r_issued;
                mul_req.a     = integ_mag;
                mul_req.b     = 32'd91;
                if (mul_rsp.done) n_prod = mul_rsp.prod[47:0];
            end
            avagc_pkg::S_I91_DIV: begin
                div_req.start    = !r_issued;
                div_req.dividend = r_prod;
                div_req.divisor  = 32'd100;
                if (div_rsp.done) n_integ = q_integ[31:0];
            end
            avagc_pkg::S_TG_DIV: begin
                div_req.start    = !r_issued;
                div_req.dividend = {8'd0, tg, 32'd0};
                div_req.divisor  = r_ph;
                if (div_rsp.done) begin
                    if (div_rsp.quot < {26'd0, avagc_pkg::MULT_MIN})
                        n_temp = avagc_pkg::MULT_MIN;
                    else if (div_rsp.quot > {26'd0, avagc_pkg::MULT_MAX})
                        n_temp = avagc_pkg::MULT_MAX;
                    else
                        n_temp = div_rsp.quot[21:0];
                end
            end
            avagc_pkg::S_ERR: begin
                n_err  = err_next;
                n_fast = (r_lvl > {14'd0, pre.zone_high, 32'd0})
                         || (r_lvl < {13'd0, sq_low, 32'd0});
            end
            avagc_pkg::S_IE_DIV: begin
                div_req.start    = !r_issued;
                div_req.dividend = {22'd0, err_mag, 4'd0};
                div_req.divisor  = 32'd125;
                if (div_rsp.done) begin
                    // Integrator saturates symmetrically at plus and minus 2^31 - 1.
                    if ($signed(isum) > 33'sd2147483647)
                        n_integ = 32'h7FFFFFFF;
                    else if ($signed(isum) < -33'sd2147483647)
                        n_integ = 32'h80000001;
                    else
                        n_integ = isum[31:0];
                end
            end
            avagc_pkg::S_I9_MUL: begin
                mul_req.start = !r_issued;
                mul_req.a     = integ_mag;
                mul_req.b     = 32'd9;
                if (mul_rsp.done) n_prod = mul_rsp.prod[47:0];
            end
            avagc_pkg::S_I9_DIV: begin
                div_req.start    = !r_issued;
                div_req.dividend = r_prod;
                div_req.divisor  = 32'd10;
                if (div_rsp.done) n_integ = q_integ[31:0];
            end
            avagc_pkg::S_KP_MUL: begin
                mul_req.start = !r_issued;
                mul_req.a     = {10'd0, err_mag};
                mul_req.b     = {24'd0, pre.kp};
                if (mul_rsp.done) n_prod = mul_rsp.prod[47:0];
            end
            avagc_pkg::S_KP_DIV: begin
                div_req.start    = !r_issued;
                div_req.dividend = r_prod;
                div_req.divisor  = {12'd0, r_fast ? pre.kp_div_fast : pre.kp_div_slow};
                if (div_rsp.done) n_q1 = q_err;
            end
            avagc_pkg::S_KI_MUL: begin
                mul_req.start = !r_issued;
                mul_req.a     = integ_mag;
                mul_req.b     = {24'd0, pre.ki};
                if (mul_rsp.done) n_prod = mul_rsp.prod[47:0];
            end
            avagc_pkg::S_KI_DIV: begin
                div_req.start    = !r_issued;
                div_req.dividend = r_prod;
                div_req.divisor  = {4'd0, r_fast ? pre.ki_div_fast : pre.ki_div_slow};
                if (div_rsp.done) n_q2 = q_integ;
            end
            avagc_pkg::S_TSUM: begin
                if ($signed(tsum) < $signed({11'd0, avagc_pkg::MULT_MIN}))
                    n_temp = avagc_pkg::MULT_MIN;
                else if ($signed(tsum) > $signed({11'd0, avagc_pkg::MULT_MAX}))
                    n_temp = avagc_pkg::MULT_MAX;
                else
                    n_temp = tsum[21:0];
            end
            avagc_pkg::S_OUT_MUL: begin
                mul_req.start = !r_issued;
                mul_req.a     = r_env;
                mul_req.b     = {10'd0, r_temp};
                if (mul_rsp.done) begin
                    n_mult = r_temp;
                    if (r_env < 32'd131072 || t_out < 48'd65536)
                        n_tq = 24'd0;
                    else if (t_out > 48'h0FF0000)
                        n_tq = 24'hFF0000;
                    else
                        n_tq = t_out[23:0];
                end
            end
            avagc_pkg::S_RAW_DIV: begin
                div_req.start    = !r_issued;
                div_req.dividend = {21'd0, raw_num};
                div_req.divisor  = 32'd327680;
                if (div_rsp.done) begin
                    n_raw = div_rsp.quot[7:0];
                    if (r_tq < 24'd65536) n_smooth = sm_half[23:0];
                end
            end
            avagc_pkg::S_SM_DIV: begin
                div_req.start    = !r_issued;
                div_req.dividend = {24'd0, sm_mag};
                div_req.divisor  = {27'd0, pre.smooth_div};
                if (div_rsp.done) begin
                    n_smooth = sm_neg ? (r_smooth - div_rsp.quot[23:0])
                                      : (r_smooth + div_rsp.quot[23:0]);
                end
            end
            avagc_pkg::S_FINISH: begin
                n_prev = {1'b0, r_agc_mode};
                if (load_out) begin
                    n_out_valid             = 1'b1;
                    n_out.volume_smooth     = r_avg[23:8];
                    n_out.volume_raw        = r_adj[23:16];
                    n_out.agc_volume_smooth = r_smooth[23:8];
                    n_out.agc_volume_raw    = r_raw;
                    n_out.gain_multiplier   = r_mult;
                    n_out.peak_event        = r_peak;
                end
            end
            default: begin
            end
        endcase

        if (mul_req.start || div_req.start) n_issued = 1'b1;
        if (mul_rsp.done || div_rsp.done) n_issued = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= avagc_pkg::S_IDLE;
            r_issued       <= 1'b0;
            r_out_valid    <= 1'b0;
            r_agc_mode     <= avagc_pkg::MODE_MANUAL;
            r_squelch      <= 8'd10;
            r_manual_gain  <= 8'd40;
            r_input_level  <= 8'd128;
            r_peak_bin     <= 8'd0;
            r_peak_vol_lim <= 8'd0;
            r_dc           <= 32'd0;
            r_env          <= 32'd0;
            r_ph           <= 32'd0;
            r_avg          <= 24'd0;
            r_smooth       <= 24'd0;
            r_mult         <= avagc_pkg::MULT_ONE;
            r_integ        <= 32'd0;
            r_raw          <= 8'd0;
            r_prev         <= 3'd7;
            r_lct          <= 32'd0;
            r_lpt          <= 32'd0;
        end else begin
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_out_valid <= n_out_valid;
            r_dc        <= n_dc;
            r_env       <= n_env;
            r_ph        <= n_ph;
            r_avg       <= n_avg;
            r_smooth    <= n_smooth;
            r_mult      <= n_mult;
            r_integ     <= n_integ;
            r_raw       <= n_raw;
            r_prev      <= n_prev;
            r_lct       <= n_lct;
            r_lpt       <= n_lpt;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    avagc_pkg::CFG_AGC_MODE:     r_agc_mode     <= i_cfg_data[1:0];
                    avagc_pkg::CFG_SQUELCH:      r_squelch      <= i_cfg_data;
                    avagc_pkg::CFG_MANUAL_GAIN:  r_manual_gain  <= i_cfg_data;
                    avagc_pkg::CFG_INPUT_LEVEL:  r_input_level  <= i_cfg_data;
                    avagc_pkg::CFG_PEAK_BIN:     r_peak_bin     <= i_cfg_data;
                    avagc_pkg::CFG_PEAK_VOL_LIM: r_peak_vol_lim <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mic      <= n_mic;
        r_now      <= n_now;
        r_ovr      <= n_ovr;
        r_prod     <= n_prod;
        r_lvl      <= n_lvl;
        r_zone_old <= n_zone_old;
        r_zone_new <= n_zone_new;
        r_adj      <= n_adj;
        r_tq       <= n_tq;
        r_temp     <= n_temp;
        r_err      <= n_err;
        r_fast     <= n_fast;
        r_peak     <= n_peak;
        r_q1       <= n_q1;
        r_q2       <= n_q2;
        r_out      <= n_out;
    end

    assign o_in_ready  = (r_state == avagc_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_mult_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mult >= avagc_pkg::MULT_MIN && r_mult <= avagc_pkg::MULT_MAX)
        else $error("gain multiplier left its range");

    a_integ_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_integ != 32'h80000000)
        else $error("integrator passed its saturation limit");

    a_done_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mul_rsp.done || div_rsp.done) |-> r_issued)
        else $error("arithmetic unit finished without a pending request");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == avagc_pkg::S_DC_DIV))
        else $error("accepted transfer did not start the sequencer");
`endif

endmodule

// ===== hw/rtl/avagc_mul.sv =====
`timescale 1ns / 1ps

module avagc_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  avagc_pkg::t_mul_req i_req,
    output avagc_pkg::t_mul_rsp o_rsp
);

    localparam int W = avagc_pkg::MUL_W;
    localparam int CW = $clog2(W);

    logic [2*W-1:0] r_p;
    logic [W-1:0]   r_a;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [W:0]     sum;

    // One multiplier bit a cycle: add the multiplicand into the upper half, shift right.
    assign sum = {1'b0, r_p[2*W-1:W]} + (r_p[0] ? {1'b0, r_a} : {(W+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_p <= {{W{1'b0}}, i_req.b};
            r_a <= i_req.a;
        end else if (r_busy) begin
            r_p <= {sum, r_p[W-1:1]};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_p;

endmodule

// ===== hw/rtl/avagc_div.sv =====
`timescale 1ns / 1ps

module avagc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  avagc_pkg::t_div_req i_req,
    output avagc_pkg::t_div_rsp o_rsp
);

    localparam int W  = avagc_pkg::DIV_W;
    localparam int DW = avagc_pkg::DIV_DW;
    localparam int CW = $clog2(W);

    logic [W-1:0]  r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   trial;
    logic          fits;

    // Restoring division: one quotient bit a cycle, dividend bits shift out of r_q.
    assign trial = {r_rem, r_q[W-1]};
    assign fits  = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_d   <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? DW'(trial - {1'b0, r_d}) : trial[DW-1:0];
            r_q   <= {r_q[W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule
